// File: design/ajac_pkg.sv
package ajac_pkg;

  localparam int COORD_WIDTH     = 14;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  // Normalize, shift, the steps and the final clamp.
  localparam int CORDIC_LAT   = CORDIC_STEPS + 3;

  localparam int ANG_W  = 32;
  localparam int CX_W   = 33;
  localparam int SQ_W   = 63;
  localparam int NORM_W = 30;

  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] HUNDRED_Q30 = 34'd10737418;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CX_W-1:0] z;
    logic                   a_zero;
    logic                   b_zero;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  function automatic logic signed [CX_W-1:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// File: design/arm_joint_angles_core.sv
// Arm joint angles: each request carries shoulder, elbow and hand positions (tdata) and
// the arm side (tuser, 1 for the mirrored right-side rules) and returns shoulder pitch,
// shoulder roll and elbow roll in signed radians with ANGLE_FRAC_BITS fraction bits, plus
// a flag for a zero-length arm segment. One request is taken every cycle unless a result
// waits at the output without m_axis_tready_i. Each result follows the elbow path: registered
// products, normalization and squares, a 32-cell square-root chain, and a 33-stage
// arctangent chain that the pitch and roll arctangents run through alongside.
module arm_joint_angles_core #(
  parameter int COORD_WIDTH     = ajac_pkg::COORD_WIDTH,
  parameter int ANGLE_FRAC_BITS = ajac_pkg::ANGLE_FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  // shoulder_x, shoulder_y, shoulder_z, elbow_x, elbow_y, elbow_z, hand_x, hand_y, hand_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // side (1 for the mirrored right-side rules)
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // shoulder_pitch, shoulder_roll, elbow_roll
  output logic [47:0] m_axis_tdata_o,
  // degenerate
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  localparam int CW      = COORD_WIDTH;
  localparam int DW      = CW + 1;
  localparam int SW      = 2 * DW + 1;
  localparam int NW      = ajac_pkg::NORM_W;
  localparam int MXW     = (SW > NW) ? SW : NW;
  localparam int LW      = $clog2(SW + 1);
  localparam int AW      = ajac_pkg::ANG_W;
  localparam int PR_DLY  = 6 + ajac_pkg::SQRT_STEPS;
  localparam int FLG_DLY = PR_DLY + ajac_pkg::CORDIC_LAT;
  localparam int LAT     = FLG_DLY + 2;
  localparam int RS      = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [34:0] RH = 35'sd1 <<< (29 - ANGLE_FRAC_BITS);

  typedef struct packed {
    logic right;
    logic y_zero;
    logic y_pos;
    logic y_neg;
    logic z_pos;
    logic z_neg;
    logic x_le0;
    logic x_ge0;
    logic degen;
  } flags_t;

  function automatic logic signed [34:0] rnd(input logic signed [34:0] v);
    return (v + RH) >>> RS;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) return 16'h7FFF;
    if (v < -35'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [SW-1:0] mag_s(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  logic en;
  logic [LAT-1:0] vld_q;

  assign en              = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 1: differences, case flags and the pitch and roll operands.
  logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, hx, hy, hz;
  logic signed [DW-1:0] dx, dy, dz, ux, uy, uz, vx, vy, vz;
  logic [DW-1:0] mx, my, mz;
  flags_t flg, flg_q;
  logic [AW-1:0] pa, pb, ra, rb;
  logic [AW-1:0] pa_q, pb_q, ra_q, rb_q;
  logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;

  assign sx = s_axis_tdata_i[0*CW +: CW];
  assign sy = s_axis_tdata_i[1*CW +: CW];
  assign sz = s_axis_tdata_i[2*CW +: CW];
  assign ex = s_axis_tdata_i[3*CW +: CW];
  assign ey = s_axis_tdata_i[4*CW +: CW];
  assign ez = s_axis_tdata_i[5*CW +: CW];
  assign hx = s_axis_tdata_i[6*CW +: CW];
  assign hy = s_axis_tdata_i[7*CW +: CW];
  assign hz = s_axis_tdata_i[8*CW +: CW];

  always_comb begin
    dx = DW'(ex) - DW'(sx);
    dy = DW'(ey) - DW'(sy);
    dz = DW'(ez) - DW'(sz);
    ux = DW'(sx) - DW'(ex);
    uy = DW'(sy) - DW'(ey);
    uz = DW'(sz) - DW'(ez);
    vx = DW'(hx) - DW'(ex);
    vy = DW'(hy) - DW'(ey);
    vz = DW'(hz) - DW'(ez);
    mx = mag_d(dx);
    my = mag_d(dy);
    mz = mag_d(dz);
    flg.right  = s_axis_tuser_i[0];
    flg.y_zero = (dy == '0);
    flg.y_pos  = (dy > 0);
    flg.y_neg  = dy[DW-1];
    flg.z_pos  = (dz > 0);
    flg.z_neg  = dz[DW-1];
    flg.x_le0  = (dx <= 0);
    flg.x_ge0  = !dx[DW-1];
    flg.degen  = (ux == '0 && uy == '0 && uz == '0) || (vx == '0 && vy == '0 && vz == '0);
    // Below the horizontal with the elbow ahead, pitch is pi/2 plus atan(z/-y).
    if (flg.y_neg && flg.z_pos) begin
      pa = AW'(mz);
      pb = AW'(my);
    end else begin
      pa = AW'(my);
      pb = AW'(mz);
    end
    ra = AW'(mx);
    rb = AW'(my);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q <= flg;
      pa_q  <= pa;
      pb_q  <= pb;
      ra_q  <= ra;
      rb_q  <= rb;
      ux_q  <= ux;
      uy_q  <= uy;
      uz_q  <= uz;
      vx_q  <= vx;
      vy_q  <= vy;
      vz_q  <= vz;
    end
  end

  // Stage 2: products for the cross and dot products.
  logic signed [2*DW-1:0] p_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= uy_q * vz_q;
      p_q[1] <= uz_q * vy_q;
      p_q[2] <= uz_q * vx_q;
      p_q[3] <= ux_q * vz_q;
      p_q[4] <= ux_q * vy_q;
      p_q[5] <= uy_q * vx_q;
      p_q[6] <= ux_q * vx_q;
      p_q[7] <= uy_q * vy_q;
      p_q[8] <= uz_q * vz_q;
    end
  end

  // Stage 3: cross components and dot product.
  logic signed [SW-1:0] c_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= SW'(p_q[0]) - SW'(p_q[1]);
      c_q[1] <= SW'(p_q[2]) - SW'(p_q[3]);
      c_q[2] <= SW'(p_q[4]) - SW'(p_q[5]);
      c_q[3] <= SW'(p_q[6]) + SW'(p_q[7]) + SW'(p_q[8]);
    end
  end

  // Stage 4: magnitudes and the common right shift that brings them below 2^30.
  logic [SW-1:0] mg [4];
  logic [SW-1:0] mg_or;
  logic [LW-1:0] len, sh;
  logic [SW-1:0] mg_q [4];
  logic [LW-1:0] sh_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mg[k] = mag_s(c_q[k]);
    end
    mg_or = mg[0] | mg[1] | mg[2] | mg[3];
    len   = '0;
    for (int i = 0; i < SW; i++) begin
      if (mg_or[i]) len = LW'(i + 1);
    end
    sh = (int'(len) > NW) ? LW'(int'(len) - NW) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mg_q[k] <= mg[k];
      end
      sh_q <= sh;
    end
  end

  // Stage 5: scaled magnitudes.
  logic [NW-1:0] an_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        an_q[k] <= NW'(MXW'(mg_q[k]) >> sh_q);
      end
    end
  end

  // Stage 6: squares of the cross components; then their sum.
  logic [2*NW-1:0] sq_q [3];
  logic [NW-1:0]   ad6_q, ad7_q;
  logic [2*NW+1:0] m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= an_q[0] * an_q[0];
      sq_q[1] <= an_q[1] * an_q[1];
      sq_q[2] <= an_q[2] * an_q[2];
      ad6_q   <= an_q[3];
      m_q     <= (2*NW+2)'(sq_q[0]) + (2*NW+2)'(sq_q[1]) + (2*NW+2)'(sq_q[2]);
      ad7_q   <= ad6_q;
    end
  end

  logic [AW-1:0] cm, ad_d;
  logic [NW-1:0] ad_n;

  ajac_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (m_q),
    .root_o(cm)
  );

  ajac_delay #(.W(NW), .N(ajac_pkg::SQRT_STEPS)) u_ad_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (ad7_q),
    .d_o  (ad_n)
  );
  assign ad_d = AW'(ad_n);

  logic [4*AW-1:0] pr_d;

  ajac_delay #(.W(4*AW), .N(PR_DLY)) u_pr_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({pa_q, pb_q, ra_q, rb_q}),
    .d_o  (pr_d)
  );

  flags_t flg_d;
  logic   dneg_d;

  ajac_delay #(.W($bits(flags_t)), .N(FLG_DLY)) u_flg_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (flg_q),
    .d_o  (flg_d)
  );

  ajac_delay #(.W(1), .N(FLG_DLY - 2)) u_dneg_dly (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (c_q[3][SW-1]),
    .d_o  (dneg_d)
  );

  logic [AW-1:0] pat, rat, eat;

  ajac_cordic u_pitch (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  (pr_d[4*AW-1:3*AW]),
    .b_i  (pr_d[3*AW-1:2*AW]),
    .ang_o(pat)
  );

  ajac_cordic u_roll (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  (pr_d[2*AW-1:AW]),
    .b_i  (pr_d[AW-1:0]),
    .ang_o(rat)
  );

  ajac_cordic u_elbow (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  (cm),
    .b_i  (ad_d),
    .ang_o(eat)
  );

  // Final stage: case selection, rounding, sign and saturation.
  logic signed [34:0] pv, rv, th, pr_r, rl_r, el_r;
  logic pneg, rneg;
  logic [15:0] pitch_q, roll_q, elbow_q;
  logic        degen_q;

  always_comb begin
    if (flg_d.y_zero) begin
      pv = $signed({1'b0, ajac_pkg::HUNDRED_Q30});
    end else if (flg_d.y_neg && flg_d.z_pos) begin
      pv = $signed({1'b0, ajac_pkg::HALF_PI_Q30}) + $signed({3'b0, pat});
    end else begin
      pv = $signed({3'b0, pat});
    end
    pneg = flg_d.y_pos && flg_d.z_neg;
    pr_r = pneg ? -rnd(pv) : rnd(pv);

    if (!flg_d.y_neg) begin
      rv = $signed({1'b0, ajac_pkg::HALF_PI_Q30});
    end else if (flg_d.right ? flg_d.x_ge0 : flg_d.x_le0) begin
      rv = $signed({1'b0, ajac_pkg::HUNDRED_Q30});
    end else begin
      rv = $signed({3'b0, rat});
    end
    // The right side mirrors every roll except the near-zero constant.
    rneg = flg_d.right && !(flg_d.y_neg && flg_d.x_ge0);
    rl_r = rneg ? -rnd(rv) : rnd(rv);

    if (dneg_d) begin
      th = $signed({1'b0, ajac_pkg::PI_Q30}) - $signed({3'b0, eat});
    end else begin
      th = $signed({3'b0, eat});
    end
    el_r = rnd(th) - rnd($signed({1'b0, ajac_pkg::PI_Q30}));
    if (flg_d.right) el_r = -el_r;
    if (flg_d.degen) el_r = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= sat16(pr_r);
      roll_q  <= sat16(rl_r);
      elbow_q <= sat16(el_r);
      degen_q <= flg_d.degen;
    end
  end

  assign m_axis_tdata_o  = {elbow_q, roll_q, pitch_q};
  assign m_axis_tuser_o  = degen_q;
  assign m_axis_tvalid_o = vld_q[LAT-1];

endmodule

// File: design/ajac_delay.sv
module ajac_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign d_o = line_q[N-1];

endmodule

// File: design/ajac_cordic_cell.sv
module ajac_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  ajac_pkg::cordic_t d_i,
  output ajac_pkg::cordic_t d_o
);

  logic signed [ajac_pkg::CX_W-1:0] dx;
  logic signed [ajac_pkg::CX_W-1:0] dy;
  ajac_pkg::cordic_t                nxt;
  ajac_pkg::cordic_t                st_q;

  always_comb begin
    dx  = d_i.y >>> STEP;
    dy  = d_i.x >>> STEP;
    nxt = d_i;
    if (d_i.y >= 0) begin
      nxt.x = d_i.x + dx;
      nxt.y = d_i.y - dy;
      nxt.z = d_i.z + ajac_pkg::atan_tab(STEP);
    end else begin
      nxt.x = d_i.x - dx;
      nxt.y = d_i.y + dy;
      nxt.z = d_i.z - ajac_pkg::atan_tab(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= nxt;
    end
  end

  assign d_o = st_q;

endmodule

// File: design/ajac_cordic.sv
module ajac_cordic (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ajac_pkg::ANG_W-1:0] a_i,
  input  logic [ajac_pkg::ANG_W-1:0] b_i,
  output logic [ajac_pkg::ANG_W-1:0] ang_o
);

  localparam int AW = ajac_pkg::ANG_W;
  localparam int LW = $clog2(AW + 1);
  localparam int TOP = ajac_pkg::NORM_W - 1;

  logic [AW-1:0] ab;
  logic [LW-1:0] len;
  logic [AW-1:0] a_q, b_q;
  logic [LW-1:0] len_q;
  logic [AW-1:0] sa, sb;
  ajac_pkg::cordic_t st [ajac_pkg::CORDIC_STEPS+1];
  ajac_pkg::cordic_t init;
  ajac_pkg::cordic_t last;
  logic [AW-1:0] ang_q;

  always_comb begin
    ab  = a_i | b_i;
    len = '0;
    for (int i = 0; i < AW; i++) begin
      if (ab[i]) len = LW'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      len_q <= len;
    end
  end

  // Bring the larger operand into [2^28, 2^29).
  always_comb begin
    if (len_q > LW'(TOP)) begin
      sa = a_q >> (len_q - LW'(TOP));
      sb = b_q >> (len_q - LW'(TOP));
    end else begin
      sa = a_q << (LW'(TOP) - len_q);
      sb = b_q << (LW'(TOP) - len_q);
    end
    init.x      = ajac_pkg::CX_W'($signed({1'b0, sb}));
    init.y      = ajac_pkg::CX_W'($signed({1'b0, sa}));
    init.z      = '0;
    init.a_zero = (a_q == '0);
    init.b_zero = (b_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st[0] <= init;
    end
  end

  for (genvar g = 0; g < ajac_pkg::CORDIC_STEPS; g++) begin : g_cell
    ajac_cordic_cell #(.STEP(g)) u_cell (
      .clk_i(clk_i),
      .en_i (en_i),
      .d_i  (st[g]),
      .d_o  (st[g+1])
    );
  end

  assign last = st[ajac_pkg::CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (last.a_zero) begin
        ang_q <= '0;
      end else if (last.b_zero) begin
        ang_q <= ajac_pkg::HALF_PI_Q30[AW-1:0];
      end else if (last.z < 0) begin
        ang_q <= '0;
      end else begin
        ang_q <= last.z[AW-1:0];
      end
    end
  end

  assign ang_o = ang_q;

endmodule

// File: design/ajac_sqrt_cell.sv
module ajac_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  ajac_pkg::sqrt_t d_i,
  output ajac_pkg::sqrt_t d_o
);

  localparam int SW = ajac_pkg::SQ_W;
  localparam logic [SW-1:0] BITV = SW'(1) << (2 * (ajac_pkg::SQRT_STEPS - 1 - STEP));

  logic [SW-1:0]   rb;
  ajac_pkg::sqrt_t nxt;
  ajac_pkg::sqrt_t st_q;

  always_comb begin
    rb = d_i.r + BITV;
    if (d_i.n >= rb) begin
      nxt.n = d_i.n - rb;
      nxt.r = (d_i.r >> 1) + BITV;
    end else begin
      nxt.n = d_i.n;
      nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= nxt;
    end
  end

  assign d_o = st_q;

endmodule

// File: design/ajac_sqrt.sv
module ajac_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2*ajac_pkg::NORM_W+1:0] m_i,
  output logic [ajac_pkg::ANG_W-1:0]    root_o
);

  ajac_pkg::sqrt_t st [ajac_pkg::SQRT_STEPS+1];

  assign st[0].n = ajac_pkg::SQ_W'(m_i);
  assign st[0].r = '0;

  for (genvar g = 0; g < ajac_pkg::SQRT_STEPS; g++) begin : g_cell
    ajac_sqrt_cell #(.STEP(g)) u_cell (
      .clk_i(clk_i),
      .en_i (en_i),
      .d_i  (st[g]),
      .d_o  (st[g+1])
    );
  end

  assign root_o = st[ajac_pkg::SQRT_STEPS].r[ajac_pkg::ANG_W-1:0];

endmodule

// File: verif/arm_joint_angles_core_tb.sv
module arm_joint_angles_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = 14;
  localparam int DIN_W  = ((9*CW+7)/8)*8;
  localparam int LAT    = 73;
  localparam longint PI_FX   = 64'd3373259426;
  localparam longint HALF_FX = 64'd1686629713;
  localparam longint HUND_FX = 64'd10737418;
  localparam int LIMIT  = 400000;

  localparam bit SIDE_LEFT  = 1'b0;
  localparam bit SIDE_RIGHT = 1'b1;

  typedef struct {
    bit                 side;
    logic signed [13:0] c [9];
  } joints_t;

  typedef struct {
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] elbow;
    logic        degen;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [DIN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;

  joints_t pending_q[$];
  angles_t angles_q[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit hold_for_drain = 0;
  int send_wait = 0;
  int recv_wait = 0;

  arm_joint_angles_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Arctangent of a/b for a, b >= 0 by CORDIC vectoring, angle at 2^-30 rad.
  function automatic longint cordic_atan(longint a, longint b);
    longint x, y, z, dx, dy;
    z = 0;
    if (a == 0) return 0;
    if (b == 0) return HALF_FX;
    while ((a | b) >= (64'sd1 << 29)) begin
      a = a >> 1;
      b = b >> 1;
    end
    while ((a | b) < (64'sd1 << 28)) begin
      a = a << 1;
      b = b << 1;
    end
    x = b;
    y = a;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ajac_pkg::atan_tab(i));
      end else begin
        x -= dx; y += dy; z -= longint'(ajac_pkg::atan_tab(i));
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint to_q13(longint v);
    return (v + (64'sd1 << 16)) >>> 17;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic angles_t joint_angles(joints_t j);
    angles_t r;
    longint s[3], e[3], h[3], u[3], w[3];
    longint x, y, z, pitch, roll, elbow, cx, cy, cz, d, ax, ay, az, ad, th;
    for (int k = 0; k < 3; k++) begin
      s[k] = j.c[k]; e[k] = j.c[3+k]; h[k] = j.c[6+k];
      u[k] = s[k] - e[k]; w[k] = h[k] - e[k];
    end
    x = e[0] - s[0]; y = e[1] - s[1]; z = e[2] - s[2];
    elbow = 0;
    if (y == 0) pitch = to_q13(HUND_FX);
    else if (y > 0) begin
      pitch = to_q13(cordic_atan(abs64(y), abs64(z)));
      if (z < 0) pitch = -pitch;
    end else if (z < 0) pitch = to_q13(cordic_atan(abs64(y), abs64(z)));
    else if (z == 0) pitch = to_q13(HALF_FX);
    else pitch = to_q13(HALF_FX + cordic_atan(abs64(z), abs64(y)));
    if (j.side == SIDE_LEFT) begin
      if (y >= 0) roll = to_q13(HALF_FX);
      else if (x <= 0) roll = to_q13(HUND_FX);
      else roll = to_q13(cordic_atan(abs64(x), abs64(y)));
    end else begin
      if (y >= 0) roll = -to_q13(HALF_FX);
      else if (x >= 0) roll = to_q13(HUND_FX);
      else roll = -to_q13(cordic_atan(abs64(x), abs64(y)));
    end
    r.degen = (u[0] == 0 && u[1] == 0 && u[2] == 0) || (w[0] == 0 && w[1] == 0 && w[2] == 0);
    if (!r.degen) begin
      cx = u[1]*w[2] - u[2]*w[1];
      cy = u[2]*w[0] - u[0]*w[2];
      cz = u[0]*w[1] - u[1]*w[0];
      d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
      ax = abs64(cx); ay = abs64(cy); az = abs64(cz); ad = abs64(d);
      while ((ax | ay | az | ad) >= (64'sd1 << 30)) begin
        ax = ax >> 1; ay = ay >> 1; az = az >> 1; ad = ad >> 1;
      end
      th = cordic_atan(root_floor(ax*ax + ay*ay + az*az), ad);
      if (d < 0) th = PI_FX - th;
      elbow = to_q13(th) - to_q13(PI_FX);
      if (j.side == SIDE_RIGHT) elbow = -elbow;
    end
    r.pitch = sat16(pitch);
    r.roll = sat16(roll);
    r.elbow = sat16(elbow);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s at cycle %0d", msg, cycles);
    errors++;
  endtask

  function automatic logic signed [13:0] rand_coord(int mode);
    case (mode)
      0: return 14'($urandom);
      1: return 14'($signed($urandom_range(0, 60)) - 30);
      default: return 14'($urandom_range(0, 1) ? 8191 : -8192);
    endcase
  endfunction

  task automatic add_joints(bit side, int sx, int sy, int sz, int ex, int ey, int ez,
                            int hx, int hy, int hz);
    joints_t j;
    j.side = side;
    j.c[0] = sx; j.c[1] = sy; j.c[2] = sz;
    j.c[3] = ex; j.c[4] = ey; j.c[5] = ez;
    j.c[6] = hx; j.c[7] = hy; j.c[8] = hz;
    pending_q = {pending_q, j};
  endtask

  initial begin
    joints_t j;
    int mode;
    for (int sd = 0; sd < 2; sd++) begin
      // Pitch and roll branches: y zero, positive, negative against z signs and zero.
      add_joints(sd, 0, 0, 0, 5, 0, 3, 9, 9, 9);
      add_joints(sd, 0, 0, 0, 5, 7, 3, 9, 9, 9);
      add_joints(sd, 0, 0, 0, -5, 7, 0, 9, 9, 9);
      add_joints(sd, 0, 0, 0, 5, 7, -3, 9, 9, 9);
      add_joints(sd, 0, 0, 0, 5, -7, -3, 9, 9, 9);
      add_joints(sd, 0, 0, 0, -5, -7, 0, 9, 9, 9);
      add_joints(sd, 0, 0, 0, 0, -7, 3, 9, 9, 9);
      // Zero-length segments.
      add_joints(sd, 4, 4, 4, 4, 4, 4, 1, 2, 3);
      add_joints(sd, 1, 2, 3, 4, 4, 4, 4, 4, 4);
      // Field extremes, straight and folded arms.
      add_joints(sd, -8192, -8192, -8192, 8191, 8191, 8191, -8192, -8192, -8192);
      add_joints(sd, 8191, 8191, 8191, -8192, -8192, -8192, 8191, -8192, 8191);
      add_joints(sd, 0, 0, 0, 10, 0, 0, 20, 0, 0);
    end
    for (int n = 0; n < 1550; n++) begin
      j.side = $urandom_range(0, 1);
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        j.c[k] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
      if ($urandom_range(0, 29) == 0) j.c[5] = j.c[2];
      if ($urandom_range(0, 29) == 0) for (int k = 0; k < 3; k++) j.c[3+k] = j.c[k];
      if ($urandom_range(0, 29) == 0) for (int k = 0; k < 3; k++) j.c[6+k] = j.c[3+k];
      if ($urandom_range(0, 9) == 0) j.c[4] = j.c[1];
      pending_q = {pending_q, j};
    end
    stim_done = 1;
  end

  // Request driver.
  always @(posedge clk) begin
    joints_t j;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        void'(pending_q.pop_front());
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (pending_q.size() == 800 && !hold_for_drain) hold_for_drain = 1;
      end
      if (hold_for_drain && angles_q.size() == 0 && !(s_tvalid && s_tready))
        hold_for_drain = 0;
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_for_drain) begin
        j = pending_q[0];
        s_tvalid <= 1'b1;
        s_tuser <= j.side;
        for (int k = 0; k < 9; k++) s_tdata[k*CW +: CW] <= j.c[k];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict on acceptance.
  always @(posedge clk) begin
    joints_t j;
    if (rst_n && s_tvalid && s_tready) begin
      j.side = s_tuser[0];
      for (int k = 0; k < 9; k++) j.c[k] = s_tdata[k*CW +: CW];
      angles_q = {angles_q, joint_angles(j)};
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    angles_t want;
    cycles++;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        if (angles_q.size() == 0) begin
          report_mismatch("unexpected result");
        end else begin
          want = angles_q.pop_front();
          if (m_tdata[15:0] !== want.pitch)
            report_mismatch($sformatf("pitch: got %0h expected %0h",
                                      m_tdata[15:0], want.pitch));
          if (m_tdata[31:16] !== want.roll)
            report_mismatch($sformatf("roll: got %0h expected %0h",
                                      m_tdata[31:16], want.roll));
          if (m_tdata[47:32] !== want.elbow)
            report_mismatch($sformatf("elbow: got %0h expected %0h",
                                      m_tdata[47:32], want.elbow));
          if (m_tuser[0] !== want.degen)
            report_mismatch($sformatf("degenerate: got %0h expected %0h",
                                      m_tuser[0], want.degen));
        end
        recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (cycles < LIMIT && (pending_q.size() > 0 || angles_q.size() > 0)) @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
    end else begin
      repeat (LAT + 20) @(posedge clk);
      if (errors == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule
